// File: hdl/wgm_pkg.sv
package wgm_pkg;

    // Item operation codes
    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_TEXT   = 2'd2,
        OP_END    = 2'd3
    } t_opcode;

    // Pattern wildcards
    localparam logic [7:0] SYM_ANY_ONE = 8'd63;
    localparam logic [7:0] SYM_ANY_RUN = 8'd42;

    typedef struct packed {
        t_opcode    opcode;
        logic [7:0] symbol;
    } t_in_item;

    typedef struct packed {
        logic matched;
        logic pattern_overflow;
    } t_out_item;

endpackage

// File: hdl/wgm_stream_if.sv
interface wgm_stream_if #(
    parameter type t_data = logic
);
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/wildcard_glob_match_top.sv
// Whole-string wildcard matcher.
// i_in carries items {opcode, symbol}: clear pattern, append pattern byte,
// text byte, end of text. In the pattern '?' matches any one byte and '*'
// any run of bytes. o_out carries {matched, pattern_overflow}, one
// transaction for each end-of-text item and none for the other opcodes.
// An accepted item is held in the input register until the core takes it to
// update the position set; an end-of-text result is then valid on o_out.
// Throughput: one item per cycle while no end-of-text item waits on a stalled
// result; the set update is a parallel compare of all stored pattern bytes
// plus a log2(MAX_PATTERN+1)-level star closure scan.
// Reset (i_rst_n low, synchronous) empties the pattern, clears overflow and
// drops any pending item and result.
// When the receiver stalls, the result stays in the output register; items
// other than end of text keep flowing, and an end-of-text item waits in the
// input register, so i_in.ready drops only when a second result is due.
module wildcard_glob_match_top #(
    parameter int MAX_PATTERN = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    wgm_stream_if.sink        i_in,
    wgm_stream_if.source      o_out
);

    logic               r_in_valid;
    wgm_pkg::t_in_item  r_in_data;
    logic               r_out_valid;
    wgm_pkg::t_out_item r_out_data;

    wgm_pkg::t_out_item core_result;
    logic               is_end;
    logic               proc_go;

    assign is_end  = (r_in_data.opcode == wgm_pkg::OP_END);
    assign proc_go = r_in_valid && (!is_end || !r_out_valid || o_out.ready);

    assign i_in.ready  = !r_in_valid || proc_go;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    // Hold the accepted transaction until the core takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_data <= i_in.data;
        end
    end

    wgm_core #(.N(MAX_PATTERN)) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (proc_go),
        .i_item   (r_in_data),
        .o_result (core_result)
    );

    // Load the result on end of text, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_go && is_end) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_go && is_end) begin
            r_out_data <= core_result;
        end
    end

    a_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc_go && is_end) |=> r_out_valid)
        else $error("end of text without a result");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc_go && is_end) |-> (!r_out_valid || o_out.ready))
        else $error("pending result overwritten");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> (r_out_valid && $stable(r_out_data)))
        else $error("stalled result changed");

endmodule

// File: hdl/wgm_closure.sv
module wgm_closure #(
    parameter int N = 32
) (
    input  logic [N:0]   i_seed,
    input  logic [N-1:0] i_star,
    output logic [N:0]   o_set
);

    localparam int LV = $clog2(N + 1);

    // g: position reached, p: position reachable from the one below through stars
    logic [N:0] g [0:LV];
    logic [N:0] p [0:LV];

    // Prefix scan: spread reach across runs of stars in log2 levels
    always_comb begin
        g[0] = i_seed;
        p[0] = {i_star, 1'b0};
        for (int l = 0; l < LV; l++) begin
            for (int j = 0; j <= N; j++) begin
                if (j >= (1 << l)) begin
                    g[l+1][j] = g[l][j] | (p[l][j] & g[l][j - (1 << l)]);
                    p[l+1][j] = p[l][j] & p[l][j - (1 << l)];
                end else begin
                    g[l+1][j] = g[l][j];
                    p[l+1][j] = p[l][j];
                end
            end
        end
        o_set = g[LV];
    end

endmodule

// File: hdl/wgm_core.sv
module wgm_core #(
    parameter int N = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  wgm_pkg::t_in_item i_item,
    output wgm_pkg::t_out_item o_result
);

    localparam int LEN_W = $clog2(N + 1);
    localparam int IDX_W = (N > 1) ? $clog2(N) : 1;

    logic [7:0]       r_store [0:N-1];
    logic [LEN_W-1:0] r_len,    n_len;
    logic [N-1:0]     r_live,   n_live;
    logic [N-1:0]     r_star,   n_star;
    logic             r_ovf,    n_ovf;
    logic [N:0]       r_active, n_active;

    logic             full;
    logic             do_append;
    logic [N-1:0]     hit;
    logic [N:0]       stepped;
    logic [N:0]       seed;

    assign full      = (r_len == LEN_W'(N));
    assign do_append = i_fire && (i_item.opcode == wgm_pkg::OP_APPEND) && !full;

    // Advance every live non-star position on a matching text byte in parallel; active stars stay
    always_comb begin
        stepped = '0;
        for (int i = 0; i < N; i++) begin
            hit[i] = r_active[i] && r_live[i] && !r_star[i] &&
                     (r_store[i] == wgm_pkg::SYM_ANY_ONE || r_store[i] == i_item.symbol);
        end
        stepped[N:1] = hit;
        stepped      = stepped | {1'b0, r_active[N-1:0] & r_star};
    end

    // Pattern bookkeeping
    always_comb begin
        n_len  = r_len;
        n_live = r_live;
        n_star = r_star;
        n_ovf  = r_ovf;
        if (i_fire) begin
            case (i_item.opcode)
                wgm_pkg::OP_CLEAR: begin
                    n_len  = '0;
                    n_live = '0;
                    n_star = '0;
                    n_ovf  = 1'b0;
                end
                wgm_pkg::OP_APPEND: begin
                    if (full) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_len = r_len + LEN_W'(1);
                        n_live[r_len[IDX_W-1:0]] = 1'b1;
                        n_star[r_len[IDX_W-1:0]] = (i_item.symbol == wgm_pkg::SYM_ANY_RUN);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Text bytes step the set, everything else restarts it at position zero
    assign seed = (i_item.opcode == wgm_pkg::OP_TEXT) ? stepped : (N+1)'(1);

    wgm_closure #(.N(N)) u_closure (
        .i_seed (seed),
        .i_star (n_star),
        .o_set  (n_active)
    );

    // End-of-text verdict from the current set
    assign o_result.matched          = r_active[r_len] && !r_ovf;
    assign o_result.pattern_overflow = r_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= '0;
            r_live   <= '0;
            r_star   <= '0;
            r_ovf    <= 1'b0;
            r_active <= (N+1)'(1);
        end else if (i_fire) begin
            r_len    <= n_len;
            r_live   <= n_live;
            r_star   <= n_star;
            r_ovf    <= n_ovf;
            r_active <= n_active;
        end
    end

    // Write the pattern byte at the current length
    always_ff @(posedge i_clk) begin
        if (do_append) begin
            r_store[r_len[IDX_W-1:0]] <= i_item.symbol;
        end
    end

    a_active_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active >> r_len) <= (N+1)'(1))
        else $error("active position beyond pattern length");

    a_star_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_star & ~r_live) == '0)
        else $error("star flag on unused position");

    a_live_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_live} + (N+1)'(1)) == ((N+1)'(1) << r_len))
        else $error("live mask disagrees with length");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> full)
        else $error("overflow set with room left");

endmodule
